// File: hdl/lgs_pkg.sv
// Shared types, constants and the cell update function for the Life row engine.
`default_nettype none

package lgs_pkg;

  localparam int ROW_W      = 64;    // cells per row
  localparam int NUM_W      = 10;    // row index width
  localparam int WIDTH_W    = 7;     // grid_width register width
  localparam int HEIGHT_W   = 11;    // grid_height register width
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [ADDR_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_GRID_HEIGHT = 3'd4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(64);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(64);

  // One accepted row together with the rows it needs, as queued for the back end.
  typedef struct packed {
    logic [ROW_W-1:0] above;
    logic [ROW_W-1:0] middle;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] mask;
    logic [NUM_W-1:0] num;
    logic             has_first;  // emits row num-1 from above/middle/row
    logic             is_last;    // emits row num with frame end
  } lgs_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lgs_q_stat_t;

  // B3/S23 over one row; a, m and b are already masked, so columns past the
  // width read as dead.
  function automatic logic [ROW_W-1:0] next_gen(
    input logic [ROW_W-1:0] a,
    input logic [ROW_W-1:0] m,
    input logic [ROW_W-1:0] b,
    input logic [ROW_W-1:0] mask
  );
    logic [ROW_W+1:0] ae;
    logic [ROW_W+1:0] me;
    logic [ROW_W+1:0] be;
    logic [3:0]       n;
    logic [ROW_W-1:0] res;
    ae = {1'b0, a, 1'b0};
    me = {1'b0, m, 1'b0};
    be = {1'b0, b, 1'b0};
    res = '0;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(ae[c]) + 4'(ae[c+1]) + 4'(ae[c+2]) + 4'(me[c]) + 4'(me[c+2])
        + 4'(be[c]) + 4'(be[c+1]) + 4'(be[c+2]);
      res[c] = me[c+1] ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
    end
    return res & mask;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lgs_front.sv
// Front end: takes rows, masks them, tracks the row window and builds jobs.
`default_nettype none

module lgs_front import lgs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [ROW_W-1:0]    in_row_cells,
  input  wire logic [WIDTH_W-1:0]  grid_width,
  input  wire logic [HEIGHT_W-1:0] grid_height,
  input  wire lgs_q_stat_t         q_stat,
  output logic                     push,
  output lgs_job_t                 push_job
);

  logic [ROW_W-1:0] above_r, above_nxt;
  logic [ROW_W-1:0] middle_r, middle_nxt;
  logic [NUM_W-1:0] rows_seen_r, rows_seen_nxt;

  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [ROW_W-1:0]    mask;
  logic [ROW_W-1:0]    row;
  logic                accept;
  logic                last;

  always_comb begin
    eff_w = grid_width;
    if (eff_w == '0) eff_w = WIDTH_W'(1);
    if (eff_w > WIDTH_W'(MAX_WIDTH)) eff_w = WIDTH_W'(MAX_WIDTH);
    eff_h = grid_height;
    if (eff_h == '0) eff_h = HEIGHT_W'(1);
    if (eff_h > HEIGHT_W'(MAX_HEIGHT)) eff_h = HEIGHT_W'(MAX_HEIGHT);
    for (int c = 0; c < ROW_W; c++) begin
      mask[c] = (WIDTH_W'(c) < eff_w);
    end
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign row      = in_row_cells & mask;
  assign last     = ({1'b0, rows_seen_r} + HEIGHT_W'(1)) >= eff_h;

  always_comb begin
    push_job.above     = above_r;
    push_job.middle    = middle_r;
    push_job.row       = row;
    push_job.mask      = mask;
    push_job.num       = rows_seen_r;
    push_job.has_first = (rows_seen_r != '0);
    push_job.is_last   = last;
    // the first row of a multi-row frame emits nothing yet
    push = accept && (push_job.has_first || last);
  end

  always_comb begin
    above_nxt     = above_r;
    middle_nxt    = middle_r;
    rows_seen_nxt = rows_seen_r;
    if (accept) begin
      if (last) begin
        above_nxt     = '0;
        middle_nxt    = '0;
        rows_seen_nxt = '0;
      end else begin
        above_nxt     = middle_r;
        middle_nxt    = row;
        rows_seen_nxt = rows_seen_r + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= '0;
      middle_r    <= '0;
      rows_seen_r <= '0;
    end else begin
      above_r     <= above_nxt;
      middle_r    <= middle_nxt;
      rows_seen_r <= rows_seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lgs_queue.sv
// Two-entry job queue between the front and back ends.
`default_nettype none

module lgs_queue import lgs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire lgs_job_t push_job,
  input  wire logic     pop,
  output lgs_job_t      head_job,
  output lgs_q_stat_t   q_stat
);

  lgs_job_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign head_job     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lgs_back.sv
// Back end: evaluates queued jobs, one result row per cycle while out_stall allows it, into the output register.
`default_nettype none

module lgs_back import lgs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lgs_job_t    head_job,
  input  wire lgs_q_stat_t q_stat,
  output logic             pop,
  output logic             phase,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [ROW_W-1:0] out_next_row,
  output logic [NUM_W-1:0] out_row_number,
  output logic             out_frame_end
);

  logic             phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] next_row_r;
  logic [NUM_W-1:0] row_number_r;
  logic             frame_end_r;

  logic             load;
  logic             second;   // producing the frame-end row of this job
  logic [ROW_W-1:0] sel_a;
  logic [ROW_W-1:0] sel_m;
  logic [ROW_W-1:0] sel_b;
  logic [ROW_W-1:0] res;
  logic [NUM_W-1:0] res_num;

  assign load   = !q_stat.empty && (!out_valid_r || !out_stall);
  assign second = phase_r || !head_job.has_first;

  always_comb begin
    if (second) begin
      sel_a   = head_job.has_first ? head_job.middle : '0;
      sel_m   = head_job.row;
      sel_b   = '0;
      res_num = head_job.num;
    end else begin
      sel_a   = head_job.above;
      sel_m   = head_job.middle;
      sel_b   = head_job.row;
      res_num = head_job.num - NUM_W'(1);
    end
    res = next_gen(sel_a, sel_m, sel_b, head_job.mask);
  end

  always_comb begin
    pop           = load && (second || !head_job.is_last);
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      phase_nxt     = !second && head_job.is_last;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      next_row_r   <= res;
      row_number_r <= res_num;
      frame_end_r  <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign phase          = phase_r;
  assign out_valid      = out_valid_r;
  assign out_next_row   = next_row_r;
  assign out_row_number = row_number_r;
  assign out_frame_end  = frame_end_r;

endmodule

`default_nettype wire

// File: hdl/life_generation_step_core.sv
// Top level of the streaming Life (B3/S23) generation engine with its register port.
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       in         in_valid/in_stall   in_row_cells[63:0]
// out_      out        out_valid/out_stall out_next_row[63:0], out_row_number[9:0],
//                                          out_frame_end
// APB       in/out     psel/penable/pready paddr[2:0], pwdata/prdata[31:0]
//
// One row transfer per cycle in while in_stall is low; each row yields zero, one or two
// result transfers. The back end evaluates one result row per cycle unless out_stall
// holds it, so the last row of a frame occupies it for two results; the two-entry job
// queue absorbs that. Result rows leave through a register, in the cycle after the back
// end picks them up. Synchronous active-low reset clears the row window, the row count,
// the queue and the output valid; registers return to width 64, height 64.
// out_stall holds the output register; the queue then fills and in_stall rises.

module life_generation_step_core import lgs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input rows
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ROW_W-1:0]  in_row_cells,
  // result rows
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ROW_W-1:0]       out_next_row,
  output logic [NUM_W-1:0]       out_row_number,
  output logic                   out_frame_end,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [WIDTH_W-1:0]  grid_width_r, grid_width_nxt;
  logic [HEIGHT_W-1:0] grid_height_r, grid_height_nxt;
  logic                cfg_wr;

  lgs_q_stat_t q_stat;
  lgs_job_t    push_job;
  lgs_job_t    head_job;
  logic        push;
  logic        pop;
  logic        phase;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (cfg_wr) begin
      unique case (paddr)
        REG_GRID_WIDTH:  grid_width_nxt  = pwdata[WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = pwdata[HEIGHT_W-1:0];
        default: ;  // no register there
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= WIDTH_RESET;
      grid_height_r <= HEIGHT_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // ---------------- datapath ----------------
  // front: masks rows, slides the above/middle window, decides what to emit
  lgs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_row_cells (in_row_cells),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  lgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // back: one next-generation row per cycle unless stalled, 64 column counters in parallel
  lgs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .phase          (phase),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_row   (out_next_row),
    .out_row_number (out_row_number),
    .out_frame_end  (out_frame_end)
  );

  // ---------------- checks ----------------
  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job queue underflow");

  // second half of a two-result job sits on a last-row job at the head
  a_phase_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    phase |-> (!q_stat.empty && head_job.is_last && head_job.has_first))
    else $error("second result pending without a last-row job");

endmodule

`default_nettype wire

// File: tb/sv/life_generation_step_core_tb.sv
// Self-checking bench for the Life row engine: random frames in, predicted rows checked out.
module life_generation_step_core_tb;
  import lgs_pkg::*;

  localparam int ROW_TARGET    = 950;     // random input rows to send
  localparam int CYCLE_LIMIT   = 400000;  // hard stop, far above a slow passing run
  localparam int SETTLE_CYCLES = 8;       // job queue plus output register, with margin
  localparam int PRINT_CAP     = 100;

  // one next-generation row as it should leave the block
  typedef struct {
    logic [ROW_W-1:0] cells;
    logic [NUM_W-1:0] num;
    logic             ends_frame;
  } life_row_t;

  // receiver stall patterns, each held for a random span
  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_BEAT} stall_pattern_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [ROW_W-1:0]    in_row_cells = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [ROW_W-1:0]    out_next_row;
  logic [NUM_W-1:0]    out_row_number;
  logic                out_frame_end;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // bench copy of the registers and the row window
  logic [WIDTH_W-1:0]  width_reg    = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg   = HEIGHT_RESET;
  logic [ROW_W-1:0]    prior_row    = '0;   // masked row r-2
  logic [ROW_W-1:0]    center_row   = '0;   // masked row r-1
  logic [NUM_W-1:0]    row_index    = '0;   // index of the next row in the frame

  life_row_t           due_rows[$];         // predicted rows not yet seen
  logic [ROW_W-1:0]    rows_to_send[$];     // rows waiting for the driver
  life_row_t           oldest_due;

  int                  mismatches   = 0;
  int                  cycle_count  = 0;
  int                  rows_queued  = 0;
  int                  burst_left   = 1;
  int                  gap_left     = 0;
  stall_pattern_t      stall_mode   = STALL_NONE;
  int                  stall_span   = 0;
  logic [7:0]          stall_tick   = '0;

  life_generation_step_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_cells   (in_row_cells),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_row   (out_next_row),
    .out_row_number (out_row_number),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Rows per frame as the block applies it: zero acts as one, big values clamp.
  function automatic int grid_rows(input int h);
    if (h < 1) return 1;
    if (h > MAX_HEIGHT) return MAX_HEIGHT;
    return h;
  endfunction

  // B3/S23 on one row; inputs are already masked, anything off the edge is dead.
  function automatic logic [ROW_W-1:0] life_rule_row(input logic [ROW_W-1:0] up,
                                                      input logic [ROW_W-1:0] mid,
                                                      input logic [ROW_W-1:0] down,
                                                      input int cols);
    logic [ROW_W-1:0] nxt;
    int               live;
    int               k;
    nxt = '0;
    for (int c = 0; c < cols; c++) begin
      live = 0;
      for (int dc = -1; dc <= 1; dc++) begin
        k = c + dc;
        if (k >= 0 && k < ROW_W) begin
          live += int'(up[k]) + int'(down[k]);
          if (dc != 0) live += int'(mid[k]);
        end
      end
      nxt[c] = mid[c] ? (live == 2 || live == 3) : (live == 3);
    end
    return nxt;
  endfunction

  // Fold one accepted row into the window and queue the rows it completes:
  // row r finishes row r-1, and the last row of a frame also finishes itself.
  task automatic advance_generation(input logic [ROW_W-1:0] raw);
    int               cols;
    int               rows;
    int               idx;
    logic [ROW_W-1:0] keep;
    logic [ROW_W-1:0] row;
    life_row_t        due;
    cols = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    keep = '1;
    if (cols < ROW_W) keep = ~({ROW_W{1'b1}} << cols);
    rows = grid_rows(int'(height_reg));
    row  = raw & keep;
    idx  = int'(row_index);
    if (idx >= 1) begin
      due.cells      = life_rule_row(prior_row, center_row, row, cols);
      due.num        = NUM_W'(idx - 1);
      due.ends_frame = 1'b0;
      due_rows.push_back(due);
    end
    // a height lowered below the rows already seen closes the frame here too
    if (idx + 1 >= rows) begin
      due.cells      = life_rule_row((idx >= 1) ? center_row : '0, row, '0, cols);
      due.num        = NUM_W'(idx);
      due.ends_frame = 1'b1;
      due_rows.push_back(due);
      prior_row  = '0;
      center_row = '0;
      row_index  = '0;
    end else begin
      prior_row  = center_row;
      center_row = row;
      row_index  = NUM_W'(idx + 1);
    end
  endtask

  // Register write: setup cycle, then access until pready; the bench copy
  // follows at the edge the block takes it.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_GRID_WIDTH) width_reg = data[WIDTH_W-1:0];
    else if (addr == REG_GRID_HEIGHT) height_reg = data[HEIGHT_W-1:0];
  endtask

  // Junk above the register width must be dropped by the block.
  task automatic set_grid(input int cols, input int rows);
    write_reg(REG_GRID_WIDTH, ($urandom << WIDTH_W) | DATA_W'(cols));
    write_reg(REG_GRID_HEIGHT, ($urandom << HEIGHT_W) | DATA_W'(rows));
  endtask

  // Mix of dense, sparse, empty, full and small oscillator rows.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom};
      2: r = '0;
      3: r = '1;
      4: r = 64'h7 << $urandom_range(0, 61);
      5: r = r & {$urandom, $urandom};
      default: ;
    endcase
    return r;
  endfunction

  // stops at the row target, so the last phase may leave a frame open
  task automatic queue_random_rows(input int n);
    repeat (n) begin
      if (rows_queued < ROW_TARGET) begin
        rows_to_send.push_back(random_row());
        rows_queued++;
      end
    end
  endtask

  // Quiet point for register writes: sender drained, every row seen, and a
  // settle wait after that for jobs that produce nothing.
  task automatic wait_idle();
    @(posedge clk);
    while (rows_to_send.size() != 0 || in_valid || due_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length with random gaps, long gap-free runs
  // now and then. Payload holds while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_generation(in_row_cells);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rows_to_send.size() != 0) begin
          in_row_cells <= rows_to_send.pop_front();
          in_valid     <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(64, 256);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: a new pattern is drawn whenever the current span runs out.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_tick[2];
    endcase
  end

  // Result check against the oldest prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d", out_row_number));
      end else begin
        oldest_due = due_rows.pop_front();
        if (out_next_row !== oldest_due.cells)
          report_mismatch($sformatf("row %0d next_row %h, want %h",
                                    oldest_due.num, out_next_row, oldest_due.cells));
        if (out_row_number !== oldest_due.num)
          report_mismatch($sformatf("row_number %0d, want %0d",
                                    out_row_number, oldest_due.num));
        if (out_frame_end !== oldest_due.ends_frame)
          report_mismatch($sformatf("row %0d frame_end %b, want %b",
                                    oldest_due.num, out_frame_end, oldest_due.ends_frame));
      end
    end
  end

  // Timeout.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int w;
    int h;
    int frame_rows;
    int spin;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // full board and corner blocks on three-row frames: edges and overcrowding
    set_grid(64, 3);
    repeat (3) rows_to_send.push_back('1);
    rows_to_send.push_back(64'hC000_0000_0000_0003);
    rows_to_send.push_back(64'hC000_0000_0000_0003);
    rows_to_send.push_back('0);
    wait_idle();

    // single-row frames: dead rows above and below every row
    set_grid(64, 1);
    rows_to_send.push_back('1);
    rows_to_send.push_back(64'h0000_0001_C000_0000);
    rows_to_send.push_back({$urandom, $urandom});
    wait_idle();

    // zero in either register acts as one
    set_grid(0, 0);
    rows_to_send.push_back('1);
    rows_to_send.push_back(64'h5);
    wait_idle();

    // oversized values clamp to 64 columns and 1024 rows
    set_grid(127, 2047);
    repeat (5) rows_to_send.push_back({$urandom, $urandom});
    wait_idle();

    // height dropped below the rows already seen: next row closes the frame
    set_grid(65, 2);
    repeat (2) rows_to_send.push_back('1);
    wait_idle();

    // narrowest grids
    set_grid(1, 4);
    repeat (4) rows_to_send.push_back('1);
    wait_idle();
    set_grid(3, 5);
    repeat (5) rows_to_send.push_back({$urandom, $urandom});

    // Random phases: mostly whole frames on small grids, sometimes a frame
    // left open so the next setting lands mid-frame.
    while (rows_queued < ROW_TARGET) begin
      wait_idle();
      if ($urandom_range(0, 19) < 14) begin
        w = $urandom_range(1, 64);
      end else begin
        case ($urandom_range(0, 6))
          0: w = 0;
          1: w = 1;
          2: w = 2;
          3: w = 63;
          4: w = 64;
          5: w = 65;
          default: w = 127;
        endcase
      end
      spin = $urandom_range(0, 19);
      if (spin < 12)      h = $urandom_range(1, 12);
      else if (spin < 17) h = $urandom_range(13, 64);
      else if (spin == 17) h = $urandom_range(0, 2);
      else if (spin == 18) h = ($urandom_range(0, 1) != 0) ? 1024 : 2047;
      else                h = $urandom_range(65, 90);
      set_grid(w, h);
      frame_rows = grid_rows(h);
      if (frame_rows >= 100) begin
        // tall frames only get a partial run; a later setting cuts them short
        queue_random_rows($urandom_range(20, 80));
      end else begin
        queue_random_rows(frame_rows * $urandom_range(1, 4));
        if ($urandom_range(0, 3) == 0) queue_random_rows($urandom_range(1, frame_rows));
      end
    end

    // drain: sender first, then the outstanding rows, then a quiet tail
    @(posedge clk);
    while (rows_to_send.size() != 0 || in_valid) @(posedge clk);
    for (spin = 0; spin < 4096 && due_rows.size() != 0; spin++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (due_rows.size() != 0)
      report_mismatch($sformatf("%0d predicted rows never came out", due_rows.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lgs_pkg.sv
hdl/lgs_front.sv
hdl/lgs_queue.sv
hdl/lgs_back.sv
hdl/life_generation_step_core.sv
tb/sv/life_generation_step_core_tb.sv
